### sv/assert_macros.svh
// Assertion macros shared by the transmitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/rcrt_pkg.sv
// Package: types, constants and code tables of the remote code repeat transmitter.
`timescale 1ns / 1ps

package rcrt_pkg;

   // Frame geometry
   localparam int FRAME_BITS      = 34;
   localparam int BIT_INDEX_WIDTH = $clog2(FRAME_BITS + 1);

   // Configuration register indexes
   localparam logic [1:0] CSR_BIT_PERIOD   = 2'd0;
   localparam logic [1:0] CSR_GAP          = 2'd1;
   localparam logic [1:0] CSR_REPEAT_TOTAL = 2'd2;

   // Configuration reset values
   localparam logic [15:0] BIT_PERIOD_RESET   = 16'd1023;
   localparam logic [15:0] GAP_RESET          = 16'd23000;
   localparam logic [3:0]  REPEAT_TOTAL_RESET = 4'd5;

   // Highest known command
   localparam logic [3:0] CMD_LAST = 4'd5;

   // Level states
   localparam logic [2:0] LEVEL_UNKNOWN = 3'd0;
   localparam logic [2:0] LEVEL_0       = 3'd1;
   localparam logic [2:0] LEVEL_1       = 3'd2;
   localparam logic [2:0] LEVEL_2       = 3'd3;
   localparam logic [2:0] LEVEL_3       = 3'd4;

   typedef struct packed {
      logic       command_valid;
      logic [3:0] command;
   } req_type;

   typedef struct packed {
      logic       tx_level;
      logic       busy_res;
      logic [2:0] level_state;
      logic [6:0] level_percent;
      logic       unknown_command;
   } rsp_type;

   // Remote code for a known command
   function automatic logic [FRAME_BITS-1:0] code_of(input logic [2:0] cmd);
      logic [FRAME_BITS-1:0] code;
      case (cmd)
         3'd0:    code = 34'h340224c41;
         3'd1:    code = 34'h040124c41;
         3'd2:    code = 34'h240324c41;
         3'd3:    code = 34'h1c00a4c41;
         3'd4:    code = 34'h381e34c41;
         3'd5:    code = 34'h143234c41;
         default: code = '0;
      endcase
      return code;
   endfunction

   // Level state reached by a known command
   function automatic logic [2:0] state_of(input logic [2:0] cmd);
      logic [2:0] st;
      case (cmd)
         3'd0:    st = LEVEL_0;
         3'd1:    st = LEVEL_1;
         3'd2:    st = LEVEL_2;
         3'd3:    st = LEVEL_3;
         3'd4:    st = LEVEL_0;
         3'd5:    st = LEVEL_3;
         default: st = LEVEL_UNKNOWN;
      endcase
      return st;
   endfunction

   // Percent shown for a level state
   function automatic logic [6:0] percent_of(input logic [2:0] st);
      logic [6:0] pct;
      case (st)
         LEVEL_1: pct = 7'd33;
         LEVEL_2: pct = 7'd67;
         LEVEL_3: pct = 7'd100;
         default: pct = 7'd0;
      endcase
      return pct;
   endfunction

endpackage

### sv/remote_code_repeat_transmitter_unit.sv
// Remote code repeat transmitter: one tick per transaction, frame shifter and repeat control.
// A result is registered and shows in the cycle after its tick transaction is accepted.
// The step logic is a single registered pass: one tick transaction per cycle, but
// the input stalls only while the result register is full and the result side stalls.
// Reset (synchronous, active high) restores the register defaults, idles the sequencer,
// empties the pending slot, sets the level state to unknown and empties the result register.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module remote_code_repeat_transmitter_unit
   import rcrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_SEND = 2'd1;
   localparam logic [1:0] PH_GAP  = 2'd2;

   localparam logic [BIT_INDEX_WIDTH-1:0] LAST_INDEX = BIT_INDEX_WIDTH'(FRAME_BITS);

   // Configuration registers
   logic [15:0] bit_period_ff;
   logic [15:0] gap_ff;
   logic [3:0]  repeat_total_ff;

   // Sequencer state
   logic [FRAME_BITS-1:0]      frame_shift_ff, frame_shift_in;
   logic [15:0]                tick_count_ff, tick_count_in;
   logic [BIT_INDEX_WIDTH-1:0] bit_index_ff, bit_index_in;
   logic [3:0]                 repeats_done_ff, repeats_done_in;
   logic [1:0]                 phase_ff, phase_in;
   logic [FRAME_BITS-1:0]      active_code_ff, active_code_in;
   logic [2:0]                 target_state_ff, target_state_in;
   logic                       pending_valid_ff, pending_valid_in;
   logic [3:0]                 pending_command_ff, pending_command_in;
   logic [2:0]                 current_state_ff, current_state_in;

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_ff_in;

   logic        req_accept;
   logic [15:0] period;
   logic [3:0]  total;
   logic [16:0] tick_inc;
   logic        take;
   logic [3:0]  take_cmd;
   logic        end_rep;
   logic        tx;
   logic        busy;
   logic        unk;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign period = (bit_period_ff == 16'd0) ? 16'd1 : bit_period_ff;
   assign total  = (repeat_total_ff == 4'd0) ? 4'd1 : repeat_total_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff   <= BIT_PERIOD_RESET;
         gap_ff          <= GAP_RESET;
         repeat_total_ff <= REPEAT_TOTAL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BIT_PERIOD:   bit_period_ff   <= csr_write_data;
            CSR_GAP:          gap_ff          <= csr_write_data;
            CSR_REPEAT_TOTAL: repeat_total_ff <= csr_write_data[3:0];
            default:          ;
         endcase
      end
   end

   // Advance the sequencer by one tick
   always_comb begin
      frame_shift_in     = frame_shift_ff;
      tick_count_in      = tick_count_ff;
      bit_index_in       = bit_index_ff;
      repeats_done_in    = repeats_done_ff;
      phase_in           = phase_ff;
      active_code_in     = active_code_ff;
      target_state_in    = target_state_ff;
      pending_valid_in   = pending_valid_ff;
      pending_command_in = pending_command_ff;
      current_state_in   = current_state_ff;
      take     = 1'b0;
      take_cmd = '0;
      end_rep  = 1'b0;
      tx       = 1'b0;
      busy     = 1'b0;
      unk      = 1'b0;
      tick_inc = '0;

      // Take a command when idle (the pending one first), else park it in the pending slot
      if (phase_ff == PH_IDLE) begin
         if (pending_valid_ff) begin
            take             = 1'b1;
            take_cmd         = pending_command_ff;
            pending_valid_in = 1'b0;
            if (req_data.command_valid) begin
               pending_valid_in   = 1'b1;
               pending_command_in = req_data.command;
            end
         end else if (req_data.command_valid) begin
            take     = 1'b1;
            take_cmd = req_data.command;
         end
         if (take) begin
            if (take_cmd <= CMD_LAST) begin
               active_code_in  = code_of(take_cmd[2:0]);
               target_state_in = state_of(take_cmd[2:0]);
               frame_shift_in  = code_of(take_cmd[2:0]);
               tick_count_in   = '0;
               bit_index_in    = '0;
               repeats_done_in = '0;
               phase_in        = PH_SEND;
            end else begin
               unk = 1'b1;
            end
         end
      end else if (req_data.command_valid) begin
         pending_valid_in   = 1'b1;
         pending_command_in = req_data.command;
      end

      // Drive the line: frame bit or gap
      tick_inc = {1'b0, tick_count_in} + 17'd1;
      if (phase_in == PH_SEND) begin
         busy = 1'b1;
         tx   = frame_shift_in[0];
         if (tick_inc >= {1'b0, period}) begin
            tick_count_in  = '0;
            frame_shift_in = frame_shift_in >> 1;
            bit_index_in   = bit_index_in + BIT_INDEX_WIDTH'(1);
            if (bit_index_in >= LAST_INDEX) begin
               bit_index_in = '0;
               if (gap_ff == 16'd0) begin
                  end_rep = 1'b1;
               end else begin
                  phase_in = PH_GAP;
               end
            end
         end else begin
            tick_count_in = tick_inc[15:0];
         end
      end else if (phase_in == PH_GAP) begin
         busy          = 1'b1;
         tick_count_in = tick_inc[15:0];
         if (tick_inc >= {1'b0, gap_ff}) begin
            end_rep = 1'b1;
         end
      end

      // Close one repeat: restart the frame or finish
      if (end_rep) begin
         repeats_done_in = repeats_done_in + 4'd1;
         tick_count_in   = '0;
         bit_index_in    = '0;
         if (repeats_done_in >= total) begin
            current_state_in = target_state_in;
            phase_in         = PH_IDLE;
         end else begin
            frame_shift_in = active_code_in;
            phase_in       = PH_SEND;
         end
      end

      rsp_ff_in.tx_level        = tx;
      rsp_ff_in.busy_res        = busy;
      rsp_ff_in.level_state     = current_state_in;
      rsp_ff_in.level_percent   = percent_of(current_state_in);
      rsp_ff_in.unknown_command = unk;
   end

   // Fill the result register on accept, drop it when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold sequencer control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff      <= '0;
         bit_index_ff       <= '0;
         repeats_done_ff    <= '0;
         phase_ff           <= PH_IDLE;
         pending_valid_ff   <= 1'b0;
         pending_command_ff <= '0;
         current_state_ff   <= LEVEL_UNKNOWN;
         target_state_ff    <= LEVEL_UNKNOWN;
         frame_shift_ff     <= '0;
         active_code_ff     <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            tick_count_ff      <= tick_count_in;
            bit_index_ff       <= bit_index_in;
            repeats_done_ff    <= repeats_done_in;
            phase_ff           <= phase_in;
            pending_valid_ff   <= pending_valid_in;
            pending_command_ff <= pending_command_in;
            current_state_ff   <= current_state_in;
            target_state_ff    <= target_state_in;
            frame_shift_ff     <= frame_shift_in;
            active_code_ff     <= active_code_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_ff_in;
      end
   end

   `ASSERT_NEXT(a_accept_fills, clock, reset,
      req_accept, rsp_valid_ff, "accepted tick gave no result")
   `ASSERT_IMPLY(a_unknown_idle, clock, reset,
      rsp_valid_ff && rsp_ff.unknown_command, !rsp_ff.busy_res, "unknown command flagged while busy")
   `ASSERT_IMPLY(a_idle_clean, clock, reset,
      phase_ff == PH_IDLE, tick_count_ff == 16'd0 && bit_index_ff == '0, "idle with counters running")
   `ASSERT_IMPLY(a_index_range, clock, reset,
      1'b1, bit_index_ff < LAST_INDEX, "bit index past frame end")

endmodule
